/* rtl/chxy_pkg.sv */
// Shared constants for the compass heading unit: datapath widths, the
// CORDIC arctangent table (2^-16 degree units) and heading wrap constants.
// No dependencies.
package chxy_pkg;

    localparam int AXIS_IN_W   = 12;
    localparam int AXIS_FRAC   = 20;
    localparam int AXIS_W      = 35;
    localparam int ANGLE_W     = 26;
    localparam int DECL_W      = 15;
    localparam int SUM_W       = 27;
    localparam int ROUND_SHIFT = 10;
    localparam int TURN_W      = SUM_W - ROUND_SHIFT;
    localparam int HEADING_W   = 15;
    localparam int TABLE_LEN   = 24;
    localparam int TABLE_W     = 22;

    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 26'sd5898240;
    localparam logic signed [SUM_W-1:0]   ROUND_HALF   = 27'sd512;
    localparam logic signed [TURN_W-1:0]  FULL_TURN    = 17'sd23040;
    localparam logic signed [TURN_W-1:0]  NEG_TURN     = -17'sd23040;
    localparam logic signed [DECL_W-1:0]  DECL_RESET   = 15'sd895;

    localparam logic [TABLE_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

endpackage

/* rtl/compass_heading_from_xy_unit.sv */
// Top level of the compass heading unit: pipelined vectoring CORDIC, declination add,
// rounding to 1/64 degree and modulo-360 wrap.
// Depends on chxy_pkg.
//
// Usage:
//   Input: drive mag_x/mag_y and raise start; a transfer happens at each rising edge with
//   start high and busy low. busy is always low, so one sample can enter every cycle.
//   Output: heading is presented for exactly one cycle with done high. The receiver
//   cannot stall, and none is needed: results leave in order at the input rate.
//   Pipeline: from the input transfer edge to the edge that samples done, a result passes
//   one pre-rotation register, one register per CORDIC iteration, one declination/round
//   register and one wrap register.
//   Throughput: one sample per cycle; each CORDIC iteration has its own adder stage.
//   Configuration: declination (1/64 degree, signed) is written through
//   cfg_valid/cfg_ready/cfg_data; cfg_ready is always high. Write only while no
//   sample is in flight.
//   Reset: rst_n clears all in-flight valid bits and sets declination to 895.
//   Both axes zero give an angle of 0, so heading is the wrapped declination.
module compass_heading_from_xy_unit #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [chxy_pkg::AXIS_IN_W-1:0]  mag_x,
    input  logic signed [chxy_pkg::AXIS_IN_W-1:0]  mag_y,
    output logic                                   done,
    output logic        [chxy_pkg::HEADING_W-1:0]  heading,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic signed [chxy_pkg::DECL_W-1:0]     cfg_data
);
    import chxy_pkg::*;

    localparam int RUN = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic signed [AXIS_W-1:0]  x_reg [0:RUN];
    logic signed [AXIS_W-1:0]  y_reg [0:RUN];
    logic signed [ANGLE_W-1:0] z_reg [0:RUN];
    logic                      zero_reg [0:RUN];
    logic                      valid_reg [0:RUN];

    logic signed [AXIS_W-1:0]  x_in;
    logic signed [AXIS_W-1:0]  y_in;
    logic signed [AXIS_W-1:0]  x_next;
    logic signed [AXIS_W-1:0]  y_next;
    logic signed [ANGLE_W-1:0] z_next;
    logic                      in_xfer;

    logic signed [DECL_W-1:0]  decl_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [TURN_W-1:0]  turn_reg;
    logic signed [TURN_W-1:0]  turn_next;
    logic                      sum_valid_reg;
    logic signed [TURN_W-1:0]  wrap_next;
    logic [HEADING_W-1:0]      heading_reg;
    logic                      done_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_xfer   = start && !busy;

    // Pre-rotation into the right half plane
    always_comb
    begin
        x_in = {{(AXIS_W-AXIS_IN_W-AXIS_FRAC){mag_x[AXIS_IN_W-1]}}, mag_x, {AXIS_FRAC{1'b0}}};
        y_in = {{(AXIS_W-AXIS_IN_W-AXIS_FRAC){mag_y[AXIS_IN_W-1]}}, mag_y, {AXIS_FRAC{1'b0}}};
        x_next = x_in;
        y_next = y_in;
        z_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next = y_in;
                y_next = -x_in;
                z_next = QUARTER_TURN;
            end
            else
            begin
                x_next = -y_in;
                y_next = x_in;
                z_next = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
        zero_reg[0] <= (mag_x == '0) && (mag_y == '0);
    end

    // One CORDIC iteration per stage
    for (genvar i = 0; i < RUN; i++)
    begin : g_stage
        logic signed [AXIS_W-1:0]  sx_next;
        logic signed [AXIS_W-1:0]  sy_next;
        logic signed [ANGLE_W-1:0] sz_next;
        logic signed [ANGLE_W-1:0] step_angle;

        assign step_angle = signed'({{(ANGLE_W-TABLE_W){1'b0}}, ATAN_TABLE[i]});

        always_comb
        begin
            if (y_reg[i] >= 0)
            begin
                sx_next = x_reg[i] + (y_reg[i] >>> i);
                sy_next = y_reg[i] - (x_reg[i] >>> i);
                sz_next = z_reg[i] + step_angle;
            end
            else
            begin
                sx_next = x_reg[i] - (y_reg[i] >>> i);
                sy_next = y_reg[i] + (x_reg[i] >>> i);
                sz_next = z_reg[i] - step_angle;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= sx_next;
            y_reg[i+1]    <= sy_next;
            z_reg[i+1]    <= sz_next;
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    // Declination add and round half up to 1/64 degree
    always_comb
    begin
        sum_next = ROUND_HALF
                 + signed'({{(SUM_W-DECL_W-ROUND_SHIFT){decl_reg[DECL_W-1]}},
                            decl_reg, {ROUND_SHIFT{1'b0}}});
        if (!zero_reg[RUN])
        begin
            sum_next = sum_next
                     + signed'({{(SUM_W-ANGLE_W){z_reg[RUN][ANGLE_W-1]}}, z_reg[RUN]});
        end
        turn_next = sum_next[SUM_W-1:ROUND_SHIFT];
    end

    // Modulo 360 degrees
    always_comb
    begin
        priority if (turn_reg < NEG_TURN)
        begin
            wrap_next = turn_reg + FULL_TURN + FULL_TURN;
        end
        else if (turn_reg < 0)
        begin
            wrap_next = turn_reg + FULL_TURN;
        end
        else if (turn_reg >= FULL_TURN)
        begin
            wrap_next = turn_reg - FULL_TURN;
        end
        else
        begin
            wrap_next = turn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg      <= DECL_RESET;
            sum_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                decl_reg <= cfg_data;
            end
            sum_valid_reg <= valid_reg[RUN];
            done_reg      <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        turn_reg    <= turn_next;
        heading_reg <= wrap_next[HEADING_W-1:0];
    end

    assign done    = done_reg;
    assign heading = heading_reg;

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading < HEADING_W'(23040)))
        else $error("heading out of range");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##(RUN+3) done)
        else $error("result missing after pipeline latency");

    a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg |-> (wrap_next >= 0 && wrap_next < FULL_TURN))
        else $error("wrap stage out of range");

endmodule

/* tb/compass_heading_checker.sv */
// Checker for the compass heading unit: watches the sample, result and
// declination channels, predicts each heading and compares it in order.
// Depends on chxy_pkg for port widths.
module compass_heading_checker #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic signed [chxy_pkg::AXIS_IN_W-1:0]  mag_x,
    input  logic signed [chxy_pkg::AXIS_IN_W-1:0]  mag_y,
    input  logic                                   done,
    input  logic        [chxy_pkg::HEADING_W-1:0]  heading,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic signed [chxy_pkg::DECL_W-1:0]     cfg_data,
    output int                                     mismatch_count,
    output int                                     in_flight
);
    import chxy_pkg::*;

    localparam int ARCTAN_LEN = 24;
    localparam longint ARCTAN_DEG16 [0:ARCTAN_LEN-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic signed [DECL_W-1:0]  declination;
    logic        [HEADING_W-1:0] expected_headings [$];
    logic        [HEADING_W-1:0] want;
    int failures = 0;
    int queued = 0;

    assign mismatch_count = failures;
    assign in_flight      = queued;

    // Vectoring CORDIC in 2^-16 degree, then declination, round, wrap.
    function automatic logic [HEADING_W-1:0] heading_of(
        input logic signed [AXIS_IN_W-1:0] x_in,
        input logic signed [AXIS_IN_W-1:0] y_in,
        input logic signed [DECL_W-1:0]    decl
    );
        longint x;
        longint y;
        longint ox;
        longint dx;
        longint dy;
        longint z;
        longint t;
        longint q;
        longint r;
        x = longint'(x_in);
        y = longint'(y_in);
        z = 0;
        if (x != 0 || y != 0)
        begin
            x = x * 1048576;
            y = y * 1048576;
            if (x < 0)
            begin
                ox = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -ox;
                    z = 90 * 65536;
                end
                else
                begin
                    x = -y;
                    y = ox;
                    z = -90 * 65536;
                end
            end
            for (int i = 0; i < CORDIC_STAGES && i < ARCTAN_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_DEG16[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_DEG16[i];
                end
            end
        end
        t = z + longint'(decl) * 1024;
        q = (t + 512) >>> 10;
        r = q % 23040;
        if (r < 0)
            r = r + 23040;
        return r[HEADING_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            declination = 15'sd895;
            expected_headings.delete();
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_headings.size() == 0)
                    report_mismatch($sformatf("heading %0d with none expected", heading));
                else
                begin
                    want = expected_headings.pop_front();
                    if (heading !== want)
                        report_mismatch($sformatf("heading %0d, expected %0d", heading, want));
                end
            end
            if (start && !busy)
                expected_headings.push_back(heading_of(mag_x, mag_y, declination));
            if (cfg_valid && cfg_ready)
                declination = cfg_data;
        end
        queued = expected_headings.size();
    end

endmodule

/* tb/compass_heading_from_xy_unit_test.sv */
// Testbench top for the compass heading unit: clock, reset, sample and
// declination stimulus, verdict. Depends on chxy_pkg, the unit and
// compass_heading_checker.
module compass_heading_from_xy_unit_test;
    import chxy_pkg::*;

    localparam int CORDIC_STAGES = 14;
    localparam int LATENCY       = CORDIC_STAGES + 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 183;
    localparam int PHASES        = 7;
    localparam int DIRECTED      = 22;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic cfg_valid;
    logic cfg_ready;
    logic signed [AXIS_IN_W-1:0] mag_x;
    logic signed [AXIS_IN_W-1:0] mag_y;
    logic        [HEADING_W-1:0] heading;
    logic signed [DECL_W-1:0]    cfg_data;

    int mismatch_count;
    int in_flight;
    int cycle_count;
    int idle_pct;
    int decl_value;

    int dir_x [DIRECTED] = '{0, 2047, -2048, 0, 0, 2047, -2048, 2047, -2048, 1, -1,
                             0, 0, -1, 1, -1, 1, -2048, -2048, -1, -5, 2047};
    int dir_y [DIRECTED] = '{0, 0, 0, 2047, -2048, 2047, -2048, -2048, 2047, 0, 0,
                             1, -1, -1, 1, 1, -1, -1, 1, -2048, 0, -1};
    int phase_idle [PHASES] = '{22, 22, 22, 70, 70, 0, 0};
    int decl_plan [PHASES] = '{895, 11520, -11520, 0, 16383, -16384, 0};

    compass_heading_from_xy_unit #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mag_x(mag_x),
        .mag_y(mag_y),
        .done(done),
        .heading(heading),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    compass_heading_checker #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) heading_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mag_x(mag_x),
        .mag_y(mag_y),
        .done(done),
        .heading(heading),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .in_flight(in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly full-range values, some near zero, some at the axis extremes.
    function automatic logic signed [AXIS_IN_W-1:0] random_axis();
        int sel;
        int k;
        sel = $urandom_range(99);
        if (sel < 70)
            return AXIS_IN_W'($urandom);
        if (sel < 85)
        begin
            k = $urandom_range(16);
            return AXIS_IN_W'(k - 8);
        end
        case ($urandom_range(4))
            0: return 12'sh7FF;
            1: return 12'sh800;
            2: return 12'sh000;
            3: return 12'sh001;
            default: return 12'shFFF;
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transfer.
    task automatic send_sample(input logic signed [AXIS_IN_W-1:0] x,
                               input logic signed [AXIS_IN_W-1:0] y);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        mag_x = x;
        mag_y = y;
        #1;
        while (busy)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (in_flight != 0)
            @(negedge clk);
    endtask

    task automatic write_declination(input int value);
        cfg_valid = 1'b1;
        cfg_data  = DECL_W'(value);
        #1;
        while (!cfg_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        start     = 1'b0;
        mag_x     = '0;
        mag_y     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        idle_pct  = 0;
        rst_n     = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = phase_idle[p];
            if (p > 0)
            begin
                drain();
                decl_value = decl_plan[p];
                if (p == PHASES - 1)
                    decl_value = int'($urandom_range(23040)) - 11520;
                write_declination(decl_value);
            end
            send_sample('0, '0);
            if (p == 0)
                for (int d = 0; d < DIRECTED; d++)
                    send_sample(AXIS_IN_W'(dir_x[d]), AXIS_IN_W'(dir_y[d]));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_axis(), random_axis());
        end
        drain();
        repeat (LATENCY + 8) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/chxy_pkg.sv
rtl/compass_heading_from_xy_unit.sv
tb/compass_heading_checker.sv
tb/compass_heading_from_xy_unit_test.sv
